// File: hdl/trm_pkg.sv
// Shared types and constants for the touch reaction map.
package trm_pkg;

  localparam int X_W        = 8;
  localparam int Y_W        = 8;
  localparam int ID_W       = 8;
  localparam int SLOT_W     = 8;
  localparam int FCNT_W     = 9;
  localparam int NFS_W      = 9;
  localparam int PAL_ENT_W  = 2 * ID_W;

  localparam int MAP_WIDTH_DEF    = 256;
  localparam int MAP_HEIGHT_DEF   = 256;
  localparam int PALETTE_SIZE_DEF = 256;

  localparam logic [NFS_W-1:0]  FIRST_SLOT     = NFS_W'(2);
  localparam logic [ID_W-1:0]   TRANSPARENT_ID = ID_W'(1);
  localparam logic [ID_W-1:0]   FIRST_ACTIVE   = ID_W'(2);
  localparam logic [FCNT_W-1:0] FCNT_RESET     = FCNT_W'(2);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_SET    = 1'b1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } st_t;

  typedef struct packed {
    logic            op;
    logic [X_W-1:0]  x;
    logic [Y_W-1:0]  y;
    logic [ID_W-1:0] press_id;
    logic [ID_W-1:0] release_id;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]   press_out;
    logic [ID_W-1:0]   release_out;
    logic              press_transparent;
    logic              release_transparent;
    logic              press_active;
    logic              release_active;
    logic              set_accepted;
    logic [SLOT_W-1:0] slot_used;
  } out_t;

endpackage

// File: hdl/touch_reaction_map.sv
// Top level: pixel map and palette of touch feedback ids.
//
//   channel   ports                              beat taken when
//   input     start, busy, in_data               start high, busy low
//   result    out_strobe, out_data               out_strobe high (one cycle)
//   config    cfg_valid, cfg_ready, cfg_data     cfg_valid and cfg_ready high
//
// Every item, set or lookup, passes registers s1, s2 and the output register;
// busy is high while an item sits in s1, so the next is taken once it is in s2.
// A lookup reads the pixel memory, then the palette memory with the slot found.
// After reset the pixel memory is cleared one entry a cycle, all MAP_WIDTH *
// MAP_HEIGHT entries (65536 by default), with busy held high; config writes
// are taken throughout. The receiver cannot stall results.
module touch_reaction_map import trm_pkg::*; #(
  parameter int MAP_WIDTH    = MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT   = MAP_HEIGHT_DEF,
  parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_strobe,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [FCNT_W-1:0] cfg_data
);

  localparam int MAP_CELLS = MAP_WIDTH * MAP_HEIGHT;
  localparam int SPAN_W    = $clog2((2**Y_W - 1) * MAP_WIDTH + 2**X_W);
  localparam int CELL_W    = $clog2(MAP_CELLS);
  localparam int AW        = (SPAN_W > CELL_W) ? SPAN_W : CELL_W;
  localparam int PAL_W     = $clog2(PALETTE_SIZE);

  st_t                  st_r, st_nxt;
  logic [CELL_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [FCNT_W-1:0]    fcnt_r;
  logic [NFS_W-1:0]     nfs_r, nfs_nxt;

  logic                 accept;
  logic [AW-1:0]        addr;
  logic                 addr_ok;
  logic [ID_W-1:0]      press_cl, release_cl;
  logic                 pal_full;
  logic                 set_go;
  logic                 clearing;

  logic                 pix_we;
  logic [CELL_W-1:0]    pix_wa;
  logic [SLOT_W-1:0]    pix_wd;
  logic [SLOT_W-1:0]    pix_q;
  logic [SLOT_W-1:0]    pix_mem [MAP_CELLS];

  logic [PAL_ENT_W-1:0] pal_q;
  logic [PAL_ENT_W-1:0] pal_mem [PALETTE_SIZE];

  logic                 s1_vld_r, s1_op_r, s1_ok_r;
  logic [SLOT_W-1:0]    s1_slot_r;
  logic                 s2_vld_r, s2_op_r, s2_ok_r;
  logic [SLOT_W-1:0]    s2_slot_r;
  logic                 slot_hit;

  logic                 out_strobe_r;
  out_t                 out_r, res_nxt;
  logic [ID_W-1:0]      res_press, res_release;
  logic                 res_hit;

  // next state
  always_comb begin
    st_nxt      = st_r;
    clr_cnt_nxt = clr_cnt_r;
    case (st_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + CELL_W'(1);
        if (clr_cnt_r == CELL_W'(MAP_CELLS - 1)) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        st_nxt = ST_RUN;
      end
      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
  end

  // outputs of the state machine
  always_comb begin
    clearing = 1'b0;
    case (st_r)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
    busy = !rst_n || clearing || s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      st_r      <= st_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= FCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fcnt_r <= cfg_data;
    end
  end

  // decode the input beat
  always_comb begin
    accept     = start && !busy;
    addr       = AW'(in_data.y) * AW'(MAP_WIDTH) + AW'(in_data.x);
    addr_ok    = {1'b0, addr} < (AW + 1)'(MAP_CELLS);
    press_cl   = ({1'b0, in_data.press_id} < fcnt_r) ? in_data.press_id : '0;
    release_cl = ({1'b0, in_data.release_id} < fcnt_r) ? in_data.release_id : '0;
    pal_full   = nfs_r >= NFS_W'(PALETTE_SIZE);
    set_go     = accept && (in_data.op == OP_SET) && !pal_full;
    nfs_nxt    = nfs_r;
    if (set_go && (press_cl != '0 || release_cl != '0)) begin
      nfs_nxt = nfs_r + NFS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nfs_r <= FIRST_SLOT;
    end else begin
      nfs_r <= nfs_nxt;
    end
  end

  // pixel memory: clear sweep or set write, read at the input address
  always_comb begin
    if (clearing) begin
      pix_we = 1'b1;
      pix_wa = clr_cnt_r;
      pix_wd = '0;
    end else begin
      pix_we = set_go && addr_ok;
      pix_wa = addr[CELL_W-1:0];
      pix_wd = nfs_r[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[pix_wa] <= pix_wd;
    end
    pix_q <= pix_mem[addr[CELL_W-1:0]];
  end

  // palette memory: claim slot on a set, read at the slot found
  always_ff @(posedge clk) begin
    if (set_go) begin
      pal_mem[nfs_r[PAL_W-1:0]] <= {press_cl, release_cl};
    end
    pal_q <= pal_mem[pix_q[PAL_W-1:0]];
  end

  // slots below the first and from the free pointer up were never filled
  assign slot_hit = (NFS_W'(pix_q) >= FIRST_SLOT) && (NFS_W'(pix_q) < nfs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= in_data.op;
      s1_ok_r   <= (in_data.op == OP_SET) ? (set_go && addr_ok) : addr_ok;
      s1_slot_r <= nfs_r[SLOT_W-1:0];
    end
    if (s1_vld_r) begin
      s2_op_r   <= s1_op_r;
      s2_ok_r   <= (s1_op_r == OP_SET) ? s1_ok_r : (s1_ok_r && slot_hit);
      s2_slot_r <= s1_slot_r;
    end
  end

  // form the result beat
  always_comb begin
    res_hit     = (s2_op_r == OP_LOOKUP) && s2_ok_r;
    res_press   = res_hit ? pal_q[PAL_ENT_W-1:ID_W] : '0;
    res_release = res_hit ? pal_q[ID_W-1:0] : '0;
    res_nxt.press_out           = res_press;
    res_nxt.release_out         = res_release;
    res_nxt.press_transparent   = res_press == TRANSPARENT_ID;
    res_nxt.release_transparent = res_release == TRANSPARENT_ID;
    res_nxt.press_active        = (res_press >= FIRST_ACTIVE) &&
                                  ({1'b0, res_press} < fcnt_r);
    res_nxt.release_active      = (res_release >= FIRST_ACTIVE) &&
                                  ({1'b0, res_release} < fcnt_r);
    res_nxt.set_accepted        = (s2_op_r == OP_SET) && s2_ok_r;
    res_nxt.slot_used           = ((s2_op_r == OP_SET) && s2_ok_r) ? s2_slot_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      out_r <= res_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

// File: hdl/trm_checker.sv
// Port-level assertions for the touch reaction map, bound to the top level.
module trm_checker import trm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input out_t              out_data
);

  a_result_three_after: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("result beat not three cycles after input beat");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("input beat taken on consecutive cycles");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.set_accepted) |-> (out_data.slot_used == '0))
    else $error("slot reported for a beat that wrote no pixel");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_data.press_transparent && out_data.press_active) &&
                   !(out_data.release_transparent && out_data.release_active))
    else $error("id flagged transparent and active at once");

endmodule

bind touch_reaction_map trm_checker u_trm_checker (.*);
